// ===== design/eaq_pkg.sv =====
// Shared constants, types and helpers for the Euler-angle to quaternion core.
// Holds the sine table builder (evaluated at elaboration) and the saturation helper.
// Depends on nothing; the core imports it (the RAM does not).
`timescale 1ns / 1ps

package eaq_pkg;

    localparam int TABLE_BITS = 12;
    localparam int FRAC_BITS  = 15;

    localparam int ANGLE_W    = 16;
    localparam int SAMPLE_W   = 16;
    localparam int ROM_SIZE   = 1 << TABLE_BITS;
    localparam int QUARTER    = ROM_SIZE >> 2;

    // Width of (a*b) >>> FRAC_BITS, of ((a*b) >>> FRAC_BITS) * c >>> FRAC_BITS, and of the sum.
    localparam int PAIR_W     = 2 * SAMPLE_W - FRAC_BITS;
    localparam int TRIP_W     = PAIR_W + SAMPLE_W - FRAC_BITS;
    localparam int SUM_W      = (TRIP_W + 1 > SAMPLE_W + 1) ? TRIP_W + 1 : SAMPLE_W + 1;

    localparam logic [63:0] HALF_PI_Q62 = 64'h6487_ED51_10B4_611A;

    typedef logic [TABLE_BITS-1:0]               t_rom_addr;
    typedef logic signed [SAMPLE_W-1:0]          t_sample;
    typedef logic [ROM_SIZE-1:0][SAMPLE_W-1:0]   t_sine_rom;

    typedef enum logic {
        FILL_SWEEP,
        FILL_DONE
    } t_fill_state;

    // Bits [125:62] of the full 128-bit product: an unsigned Q2.62 multiply.
    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return prod[125:62];
    endfunction

    // Unsigned 64-bit quotient by restoring long division, one bit per step.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        int          b;
        rem = '0;
        quo = '0;
        for (b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // First quadrant by a Taylor series in Q2.62, the rest by symmetry.
    function automatic t_sine_rom build_sine_rom();
        t_sine_rom   rom;
        logic [63:0] frac;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] p1;
        logic [63:0] p2;
        logic [63:0] v;
        logic [63:0] rnd;
        logic [63:0] div;
        int          k;
        int          n;
        for (k = 0; k < ROM_SIZE; k++) begin
            if (k <= QUARTER) begin
                frac = 64'(k) << (64 - TABLE_BITS);
                x    = mul_q62(HALF_PI_Q62, frac);
                x2   = mul_q62(x, x);
                term = x;
                sum  = x;
                for (n = 1; n <= 12; n++) begin
                    div  = 64'((2 * n) * (2 * n + 1));
                    term = udiv64(mul_q62(term, x2), div);
                    if (n % 2 == 1) begin
                        sum = sum - term;
                    end else begin
                        sum = sum + term;
                    end
                end
                p1  = {32'd0, sum[31:0]} * 64'd32767;
                p2  = {32'd0, sum[63:32]} * 64'd32767;
                v   = (p2 << 2) + (p1 >> 30);
                rnd = (v + 64'h0000_0000_8000_0000) >> 32;
                rom[k] = rnd[SAMPLE_W-1:0];
            end else if (k <= 2 * QUARTER) begin
                rom[k] = rom[2 * QUARTER - k];
            end else begin
                rom[k] = -rom[k - 2 * QUARTER];
            end
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = build_sine_rom();

    // Clamp a sum to the 16-bit two's complement range.
    function automatic t_sample sat_sample(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'(signed'(SAMPLE_W'(16'sh7FFF)));
        lo = SUM_W'(signed'(SAMPLE_W'(16'sh8000)));
        if (v > hi) begin
            return t_sample'(16'sh7FFF);
        end else if (v < lo) begin
            return t_sample'(16'sh8000);
        end else begin
            return v[SAMPLE_W-1:0];
        end
    endfunction

endpackage

// ===== design/eaq_ram.sv =====
// Generic single-write, dual-read RAM with registered read data.
// Used to hold the sine table; no package dependency.
`timescale 1ns / 1ps

module eaq_ram #(
    parameter int  WIDTH  = 16,
    parameter int  DEPTH  = 4096,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr_a,
    input  logic [ADDR_W-1:0] i_raddr_b,
    output logic [WIDTH-1:0]  o_rdata_a,
    output logic [WIDTH-1:0]  o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ===== design/euler_angles_to_quaternion_core.sv =====
// Euler-angle to quaternion core: four register stages (table read, pair products,
// triple products, saturated sums). Throughput: one transfer per cycle while the
// master side accepts; each sine RAM serves the sine and cosine reads of a transfer
// through its two read ports.
// Reset (synchronous, active low) empties the pipeline and starts a table fill of
// ROM_SIZE entries (4096 by default), during which s_axis_tready stays low.
`timescale 1ns / 1ps

module euler_angles_to_quaternion_core
    import eaq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [15:0] angle_x, [31:16] angle_y, [47:32] angle_z
    input  logic [3*ANGLE_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [15:0] quat_u, [31:16] quat_i, [47:32] quat_j, [63:48] quat_k
    output logic [4*SAMPLE_W-1:0] m_axis_tdata
);

    // ------------------------------------------------------------------
    // Table fill. The three sine RAMs are written in parallel, one entry
    // per cycle, from the elaborated table. Inputs are refused until the
    // sweep finishes.
    // ------------------------------------------------------------------
    t_fill_state r_state;
    t_fill_state n_state;
    t_rom_addr   r_fill_addr;
    t_rom_addr   n_fill_addr;
    logic        fill_we;
    logic        fill_done;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            FILL_SWEEP: begin
                if (r_fill_addr == t_rom_addr'(ROM_SIZE - 1)) begin
                    n_state = FILL_DONE;
                end
            end
            FILL_DONE: begin
                n_state = FILL_DONE;
            end
            default: begin
                n_state = FILL_SWEEP;
            end
        endcase
    end

    always_comb begin
        fill_we     = 1'b0;
        fill_done   = 1'b0;
        n_fill_addr = r_fill_addr;
        unique case (r_state)
            FILL_SWEEP: begin
                fill_we     = 1'b1;
                n_fill_addr = r_fill_addr + t_rom_addr'(1);
            end
            FILL_DONE: begin
                fill_done = 1'b1;
            end
            default: begin
                fill_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= FILL_SWEEP;
            r_fill_addr <= '0;
        end else begin
            r_state     <= n_state;
            r_fill_addr <= n_fill_addr;
        end
    end

    // ------------------------------------------------------------------
    // Flow control. Each stage loads when it is empty or its contents move
    // on, so bubbles are squeezed out and a stall drops nothing.
    // ------------------------------------------------------------------
    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic r_v4;
    logic rdy1;
    logic rdy2;
    logic rdy3;
    logic rdy4;
    logic in_xfer;

    assign rdy4          = !r_v4 || m_axis_tready;
    assign rdy3          = !r_v3 || rdy4;
    assign rdy2          = !r_v2 || rdy3;
    assign rdy1          = !r_v1 || rdy2;
    assign s_axis_tready = rdy1 && fill_done;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= in_xfer;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
            if (rdy4) begin
                r_v4 <= r_v3;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: table lookup. The half angle is an arithmetic shift right by
    // one; its top TABLE_BITS bits index the sine, and the same index plus a
    // quarter turn (wrapping) gives the cosine. The RAM output registers are
    // the stage 1 registers.
    // ------------------------------------------------------------------
    logic [ANGLE_W-1:0] ang_x;
    logic [ANGLE_W-1:0] ang_y;
    logic [ANGLE_W-1:0] ang_z;
    logic [ANGLE_W-1:0] half_x;
    logic [ANGLE_W-1:0] half_y;
    logic [ANGLE_W-1:0] half_z;
    t_rom_addr          sin_idx_x;
    t_rom_addr          sin_idx_y;
    t_rom_addr          sin_idx_z;
    t_rom_addr          cos_idx_x;
    t_rom_addr          cos_idx_y;
    t_rom_addr          cos_idx_z;

    assign ang_x  = s_axis_tdata[ANGLE_W-1:0];
    assign ang_y  = s_axis_tdata[2*ANGLE_W-1:ANGLE_W];
    assign ang_z  = s_axis_tdata[3*ANGLE_W-1:2*ANGLE_W];

    assign half_x = {ang_x[ANGLE_W-1], ang_x[ANGLE_W-1:1]};
    assign half_y = {ang_y[ANGLE_W-1], ang_y[ANGLE_W-1:1]};
    assign half_z = {ang_z[ANGLE_W-1], ang_z[ANGLE_W-1:1]};

    assign sin_idx_x = half_x[ANGLE_W-1 -: TABLE_BITS];
    assign sin_idx_y = half_y[ANGLE_W-1 -: TABLE_BITS];
    assign sin_idx_z = half_z[ANGLE_W-1 -: TABLE_BITS];
    assign cos_idx_x = sin_idx_x + t_rom_addr'(QUARTER);
    assign cos_idx_y = sin_idx_y + t_rom_addr'(QUARTER);
    assign cos_idx_z = sin_idx_z + t_rom_addr'(QUARTER);

    logic [SAMPLE_W-1:0] fill_data;
    logic [SAMPLE_W-1:0] rd_sx;
    logic [SAMPLE_W-1:0] rd_cx;
    logic [SAMPLE_W-1:0] rd_sy;
    logic [SAMPLE_W-1:0] rd_cy;
    logic [SAMPLE_W-1:0] rd_sz;
    logic [SAMPLE_W-1:0] rd_cz;

    assign fill_data = SINE_ROM[r_fill_addr];

    eaq_ram #(.WIDTH(SAMPLE_W), .DEPTH(ROM_SIZE)) u_ram_x (
        .i_clk     (i_clk),
        .i_we      (fill_we),
        .i_waddr   (r_fill_addr),
        .i_wdata   (fill_data),
        .i_re      (rdy1),
        .i_raddr_a (sin_idx_x),
        .i_raddr_b (cos_idx_x),
        .o_rdata_a (rd_sx),
        .o_rdata_b (rd_cx)
    );

    eaq_ram #(.WIDTH(SAMPLE_W), .DEPTH(ROM_SIZE)) u_ram_y (
        .i_clk     (i_clk),
        .i_we      (fill_we),
        .i_waddr   (r_fill_addr),
        .i_wdata   (fill_data),
        .i_re      (rdy1),
        .i_raddr_a (sin_idx_y),
        .i_raddr_b (cos_idx_y),
        .o_rdata_a (rd_sy),
        .o_rdata_b (rd_cy)
    );

    eaq_ram #(.WIDTH(SAMPLE_W), .DEPTH(ROM_SIZE)) u_ram_z (
        .i_clk     (i_clk),
        .i_we      (fill_we),
        .i_waddr   (r_fill_addr),
        .i_wdata   (fill_data),
        .i_re      (rdy1),
        .i_raddr_a (sin_idx_z),
        .i_raddr_b (cos_idx_z),
        .o_rdata_a (rd_sz),
        .o_rdata_b (rd_cz)
    );

    // ------------------------------------------------------------------
    // Stage 2: the four distinct x-y pair products, floored by FRAC_BITS.
    // The z sine and cosine ride along for the next multiply.
    // ------------------------------------------------------------------
    t_sample w_sx;
    t_sample w_cx;
    t_sample w_sy;
    t_sample w_cy;

    assign w_sx = rd_sx;
    assign w_cx = rd_cx;
    assign w_sy = rd_sy;
    assign w_cy = rd_cy;

    logic signed [2*SAMPLE_W-1:0] w_m_cc;
    logic signed [2*SAMPLE_W-1:0] w_m_ss;
    logic signed [2*SAMPLE_W-1:0] w_m_sc;
    logic signed [2*SAMPLE_W-1:0] w_m_cs;

    assign w_m_cc = (2*SAMPLE_W)'(w_cx) * (2*SAMPLE_W)'(w_cy);
    assign w_m_ss = (2*SAMPLE_W)'(w_sx) * (2*SAMPLE_W)'(w_sy);
    assign w_m_sc = (2*SAMPLE_W)'(w_sx) * (2*SAMPLE_W)'(w_cy);
    assign w_m_cs = (2*SAMPLE_W)'(w_cx) * (2*SAMPLE_W)'(w_sy);

    logic signed [PAIR_W-1:0] r_p_cc;
    logic signed [PAIR_W-1:0] r_p_ss;
    logic signed [PAIR_W-1:0] r_p_sc;
    logic signed [PAIR_W-1:0] r_p_cs;
    t_sample                  r_sz2;
    t_sample                  r_cz2;

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r_p_cc <= w_m_cc[2*SAMPLE_W-1:FRAC_BITS];
            r_p_ss <= w_m_ss[2*SAMPLE_W-1:FRAC_BITS];
            r_p_sc <= w_m_sc[2*SAMPLE_W-1:FRAC_BITS];
            r_p_cs <= w_m_cs[2*SAMPLE_W-1:FRAC_BITS];
            r_sz2  <= rd_sz;
            r_cz2  <= rd_cz;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: the eight triple products, each floored by FRAC_BITS.
    // Names give the x, y, z factors in order (c = cosine, s = sine).
    // ------------------------------------------------------------------
    localparam int PROD_W = PAIR_W + SAMPLE_W;

    logic signed [PROD_W-1:0] w_m_ccc;
    logic signed [PROD_W-1:0] w_m_sss;
    logic signed [PROD_W-1:0] w_m_ccs;
    logic signed [PROD_W-1:0] w_m_ssc;
    logic signed [PROD_W-1:0] w_m_scc;
    logic signed [PROD_W-1:0] w_m_css;
    logic signed [PROD_W-1:0] w_m_csc;
    logic signed [PROD_W-1:0] w_m_scs;

    assign w_m_ccc = PROD_W'(r_p_cc) * PROD_W'(r_cz2);
    assign w_m_sss = PROD_W'(r_p_ss) * PROD_W'(r_sz2);
    assign w_m_ccs = PROD_W'(r_p_cc) * PROD_W'(r_sz2);
    assign w_m_ssc = PROD_W'(r_p_ss) * PROD_W'(r_cz2);
    assign w_m_scc = PROD_W'(r_p_sc) * PROD_W'(r_cz2);
    assign w_m_css = PROD_W'(r_p_cs) * PROD_W'(r_sz2);
    assign w_m_csc = PROD_W'(r_p_cs) * PROD_W'(r_cz2);
    assign w_m_scs = PROD_W'(r_p_sc) * PROD_W'(r_sz2);

    logic signed [TRIP_W-1:0] r_t_ccc;
    logic signed [TRIP_W-1:0] r_t_sss;
    logic signed [TRIP_W-1:0] r_t_ccs;
    logic signed [TRIP_W-1:0] r_t_ssc;
    logic signed [TRIP_W-1:0] r_t_scc;
    logic signed [TRIP_W-1:0] r_t_css;
    logic signed [TRIP_W-1:0] r_t_csc;
    logic signed [TRIP_W-1:0] r_t_scs;

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r_t_ccc <= w_m_ccc[PROD_W-1:FRAC_BITS];
            r_t_sss <= w_m_sss[PROD_W-1:FRAC_BITS];
            r_t_ccs <= w_m_ccs[PROD_W-1:FRAC_BITS];
            r_t_ssc <= w_m_ssc[PROD_W-1:FRAC_BITS];
            r_t_scc <= w_m_scc[PROD_W-1:FRAC_BITS];
            r_t_css <= w_m_css[PROD_W-1:FRAC_BITS];
            r_t_csc <= w_m_csc[PROD_W-1:FRAC_BITS];
            r_t_scs <= w_m_scs[PROD_W-1:FRAC_BITS];
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: signed sums, saturated to 16 bits, into the output register.
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0] w_sum_u;
    logic signed [SUM_W-1:0] w_sum_i;
    logic signed [SUM_W-1:0] w_sum_j;
    logic signed [SUM_W-1:0] w_sum_k;

    assign w_sum_u = SUM_W'(r_t_ccc) + SUM_W'(r_t_sss);
    assign w_sum_i = SUM_W'(r_t_ccs) - SUM_W'(r_t_ssc);
    assign w_sum_j = SUM_W'(r_t_scc) + SUM_W'(r_t_css);
    assign w_sum_k = SUM_W'(r_t_csc) - SUM_W'(r_t_scs);

    t_sample r_qu;
    t_sample r_qi;
    t_sample r_qj;
    t_sample r_qk;

    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            r_qu <= sat_sample(w_sum_u);
            r_qi <= sat_sample(w_sum_i);
            r_qj <= sat_sample(w_sum_j);
            r_qk <= sat_sample(w_sum_k);
        end
    end

    assign m_axis_tvalid = r_v4;
    assign m_axis_tdata  = {r_qk, r_qj, r_qi, r_qu};

    // ------------------------------------------------------------------
    // Checks on the fill sequencer, the stage handoff and output saturation.
    // ------------------------------------------------------------------
`ifndef SYNTH
    a_no_input_during_fill: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == FILL_SWEEP) |-> !s_axis_tready
    ) else $error("input accepted while the sine table is being filled");

    a_stage_handoff: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && rdy3) |=> r_v3
    ) else $error("item lost between the pair and triple product stages");

    a_sat_high: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && rdy4 && (w_sum_u > SUM_W'(signed'(16'sh7FFF))))
            |=> (m_axis_tdata[SAMPLE_W-1:0] == 16'h7FFF)
    ) else $error("scalar part did not saturate at the positive bound");

    a_fill_length: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == FILL_SWEEP && r_fill_addr != t_rom_addr'(ROM_SIZE - 1))
            |=> (r_state == FILL_SWEEP)
    ) else $error("table fill ended before the last entry was written");
`endif

endmodule
